// ----- design/bac_pkg.sv -----
package bac_pkg;

   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_CONNECT = 2'd1;
   localparam logic [1:0] CMD_END     = 2'd2;

   localparam logic [3:0] ST_ADMIT_NEW    = 4'd0;
   localparam logic [3:0] ST_ADMIT_EXIST  = 4'd1;
   localparam logic [3:0] ST_REFUSE_CAP   = 4'd2;
   localparam logic [3:0] ST_REFUSE_FULL  = 4'd3;
   localparam logic [3:0] ST_REL_LAST     = 4'd4;
   localparam logic [3:0] ST_REL_ACTIVE   = 4'd5;
   localparam logic [3:0] ST_UNKNOWN      = 4'd6;
   localparam logic [3:0] ST_RULE_STORED  = 4'd7;
   localparam logic [3:0] ST_RULE_FULL    = 4'd8;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [19:0] DEFAULT_RATE_RESET = 20'd1000;

   localparam logic REG_MAX_TPUT    = 1'b0;
   localparam logic REG_DEFAULT_RATE = 1'b1;

   // search token moving along the cell row
   typedef struct packed {
      logic        valid;
      logic [31:0] addr;
      logic        rule_hit;
      logic [19:0] rule_rate;
      logic        client_hit;
      logic [15:0] client_count;
   } token_type;

endpackage

// ----- design/bandwidth_admission_control_core.sv -----
// Bandwidth admission controller. Each transaction loads a rate rule, opens
// or closes a client connection, and returns exactly one result. Rules and
// clients live in a row of cells (max(RULE_ENTRIES, CLIENT_ENTRIES) long); a
// search token walks the row one cell per cycle. Every transaction makes two
// passes (the second re-reads the rate and count after the update); its result
// is registered after the second pass, later while the result channel stalls,
// and the next transaction can be taken once the result has appeared.
// One transaction is handled at a time; a finished result sits in the output
// register while the next transaction is taken.
module bandwidth_admission_control_core #(
   parameter int RULE_ENTRIES   = 64,
   parameter int CLIENT_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_client_addr,
   input  logic [19:0] req_rule_rate_kbps,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [31:0] rsp_allocated_kbps,
   output logic [19:0] rsp_lookup_rate_kbps,
   output logic [15:0] rsp_active_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bac_pkg::*;

   localparam int N  = (RULE_ENTRIES > CLIENT_ENTRIES) ? RULE_ENTRIES : CLIENT_ENTRIES;
   localparam int RW = $clog2(RULE_ENTRIES + 1);
   localparam int CW = $clog2(CLIENT_ENTRIES + 1);
   localparam int IW = (N > 1) ? $clog2(N) : 1;
   localparam int KW = $clog2(N + 2);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN1 = 3'd1;
   localparam logic [2:0] S_UPD   = 3'd2;
   localparam logic [2:0] S_SCAN2 = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] max_tput_ff;
   logic [19:0] def_rate_ff;
   logic [RW-1:0] rule_fill_ff;
   logic [CW-1:0] client_fill_ff;
   logic [31:0] total_ff;
   logic [KW-1:0] cnt_ff;
   logic [1:0]  cmd_ff;
   logic [31:0] addr_ff;
   logic [19:0] rrate_ff;
   logic [3:0]  status_ff;
   logic        tok_hit_ff;
   logic [IW-1:0] tok_idx_ff;
   token_type   res_ff;

   logic        out_valid_ff;
   logic [3:0]  out_status_ff;
   logic [31:0] out_total_ff;
   logic [19:0] out_rate_ff;
   logic [15:0] out_count_ff;

   token_type chain [N+1];
   token_type inject;
   logic      rule_load, client_load, count_load;
   logic [IW-1:0] load_idx;
   logic [15:0] load_count;
   logic [32:0] fit_sum;
   logic [19:0] rate1;
   logic        accept, cfg_wr, out_free;

   assign accept   = req_valid && !req_stall;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign req_stall = reset || (state_ff != S_IDLE);
   assign cfg_wr   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? {12'd0, def_rate_ff} : max_tput_ff;

   always_comb begin
      inject = '0;
      inject.addr = addr_ff;
      inject.valid = (state_ff == S_SCAN1 || state_ff == S_SCAN2) && cnt_ff == '0;
   end
   assign chain[0] = inject;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         bac_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .rule_load  (rule_load),
            .rule_sel   (load_idx == IW'(g)),
            .client_load(client_load),
            .client_sel (load_idx == IW'(g)),
            .count_load (count_load),
            .load_addr  (addr_ff),
            .load_rate  (rrate_ff),
            .load_count (load_count),
            .rule_used  (32'(g) < 32'(rule_fill_ff) && g < RULE_ENTRIES),
            .client_used(32'(g) < 32'(client_fill_ff) && g < CLIENT_ENTRIES),
            .tok_in     (chain[g]),
            .tok_out    (chain[g+1])
         );
      end
   endgenerate

   // index of the client hit is the cell at which the token's client hit first appears
   logic [N:0] hit_vec;
   always_comb begin
      for (int k = 0; k <= N; k++) begin
         hit_vec[k] = chain[k].valid && chain[k].client_hit;
      end
   end

   assign rate1   = res_ff.rule_hit ? res_ff.rule_rate : def_rate_ff;
   assign fit_sum = {1'b0, total_ff} + {13'd0, rate1};

   logic [31:0] total_in;
   logic [3:0]  status_in;
   always_comb begin
      rule_load = 1'b0;
      client_load = 1'b0;
      count_load = 1'b0;
      load_idx = tok_idx_ff;
      load_count = res_ff.client_count;
      total_in = total_ff;
      status_in = ST_UNKNOWN;
      if (state_ff == S_UPD) begin
         case (cmd_ff)
            CMD_LOAD: begin
               load_idx = IW'(rule_fill_ff);
               if (32'(rule_fill_ff) < RULE_ENTRIES) begin
                  rule_load = 1'b1;
                  status_in = ST_RULE_STORED;
               end else begin
                  status_in = ST_RULE_FULL;
               end
            end
            CMD_CONNECT: begin
               if (res_ff.client_hit && res_ff.client_count != 16'd0) begin
                  count_load = 1'b1;
                  if (res_ff.client_count != COUNT_MAX) begin
                     load_count = res_ff.client_count + 16'd1;
                  end
                  status_in = ST_ADMIT_EXIST;
               end else if (fit_sum > {1'b0, max_tput_ff}) begin
                  status_in = ST_REFUSE_CAP;
               end else if (res_ff.client_hit) begin
                  count_load = 1'b1;
                  load_count = 16'd1;
                  total_in = fit_sum[31:0];
                  status_in = ST_ADMIT_NEW;
               end else if (32'(client_fill_ff) < CLIENT_ENTRIES) begin
                  load_idx = IW'(client_fill_ff);
                  client_load = 1'b1;
                  count_load = 1'b1;
                  load_count = 16'd1;
                  total_in = fit_sum[31:0];
                  status_in = ST_ADMIT_NEW;
               end else begin
                  status_in = ST_REFUSE_FULL;
               end
            end
            CMD_END: begin
               if (res_ff.client_hit && res_ff.client_count != 16'd0) begin
                  count_load = 1'b1;
                  load_count = res_ff.client_count - 16'd1;
                  if (res_ff.client_count == 16'd1) begin
                     total_in = (total_ff >= {12'd0, rate1}) ?
                                total_ff - {12'd0, rate1} : 32'd0;
                     status_in = ST_REL_LAST;
                  end else begin
                     status_in = ST_REL_ACTIVE;
                  end
               end
            end
            default: status_in = ST_UNKNOWN;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_SCAN1;
         S_SCAN1: if (chain[N].valid) state_in = S_UPD;
         S_UPD:   state_in = S_SCAN2;
         S_SCAN2: if (chain[N].valid) state_in = S_OUT;
         S_OUT:   if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         addr_ff  <= req_client_addr;
         rrate_ff <= req_rule_rate_kbps;
      end
      if (state_ff == S_SCAN1 || state_ff == S_SCAN2) begin
         cnt_ff <= cnt_ff + KW'(1);
         for (int k = 1; k <= N; k++) begin
            if (hit_vec[k] && !hit_vec[k-1] && !tok_hit_ff) begin
               tok_hit_ff <= 1'b1;
               tok_idx_ff <= IW'(k - 1);
            end
         end
      end else begin
         cnt_ff <= '0;
         tok_hit_ff <= 1'b0;
      end
      if (chain[N].valid) begin
         res_ff <= chain[N];
      end
      if (state_ff == S_UPD) begin
         status_ff <= status_in;
      end
      if (state_ff == S_OUT && out_free) begin
         out_status_ff <= status_ff;
         out_total_ff  <= total_ff;
         out_rate_ff   <= res_ff.rule_hit ? res_ff.rule_rate : def_rate_ff;
         out_count_ff  <= res_ff.client_hit ? res_ff.client_count : 16'd0;
      end
      if (reset) begin
         state_ff       <= S_IDLE;
         max_tput_ff    <= '0;
         def_rate_ff    <= DEFAULT_RATE_RESET;
         rule_fill_ff   <= '0;
         client_fill_ff <= '0;
         total_ff       <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg_wr) begin
            case (csr_paddr[2])
               REG_MAX_TPUT:     max_tput_ff <= csr_pwdata;
               REG_DEFAULT_RATE: def_rate_ff <= csr_pwdata[19:0];
               default: ;
            endcase
         end
         if (rule_load) rule_fill_ff <= rule_fill_ff + RW'(1);
         if (client_load) client_fill_ff <= client_fill_ff + CW'(1);
         total_ff <= total_in;
         if (state_ff == S_OUT && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = out_status_ff;
   assign rsp_allocated_kbps   = out_total_ff;
   assign rsp_lookup_rate_kbps = out_rate_ff;
   assign rsp_active_count     = out_count_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(rule_fill_ff) <= RULE_ENTRIES && 32'(client_fill_ff) <= CLIENT_ENTRIES)
      else $error("fill count overflow");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("transaction taken while busy");
   a_total_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD && status_in == ST_ADMIT_NEW) |-> fit_sum <= {1'b0, max_tput_ff})
      else $error("reservation beyond limit");

endmodule

// ----- design/bac_cell.sv -----
module bac_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                rule_load,
   input  logic                rule_sel,
   input  logic                client_load,
   input  logic                client_sel,
   input  logic                count_load,
   input  logic [31:0]         load_addr,
   input  logic [19:0]         load_rate,
   input  logic [15:0]         load_count,
   input  logic                rule_used,
   input  logic                client_used,
   input  bac_pkg::token_type  tok_in,
   output bac_pkg::token_type  tok_out
);
   import bac_pkg::*;

   logic [31:0] rule_addr_ff;
   logic [19:0] rule_rate_ff;
   logic [31:0] client_addr_ff;
   logic [15:0] client_count_ff;
   token_type   tok_ff;
   token_type   tok_in_w;
   logic        rule_match;
   logic        client_match;

   assign rule_match   = rule_used && !tok_in.rule_hit && (rule_addr_ff == tok_in.addr);
   assign client_match = client_used && !tok_in.client_hit &&
                         (client_addr_ff == tok_in.addr);

   always_comb begin
      tok_in_w = tok_in;
      if (rule_match) begin
         tok_in_w.rule_hit  = 1'b1;
         tok_in_w.rule_rate = rule_rate_ff;
      end
      if (client_match) begin
         tok_in_w.client_hit   = 1'b1;
         tok_in_w.client_count = client_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rule_load && rule_sel) begin
         rule_addr_ff <= load_addr;
         rule_rate_ff <= load_rate;
      end
      if (client_load && client_sel) begin
         client_addr_ff <= load_addr;
      end
      if (count_load && client_sel) begin
         client_count_ff <= load_count;
      end
      tok_ff.addr         <= tok_in_w.addr;
      tok_ff.rule_hit     <= tok_in_w.rule_hit;
      tok_ff.rule_rate    <= tok_in_w.rule_rate;
      tok_ff.client_hit   <= tok_in_w.client_hit;
      tok_ff.client_count <= tok_in_w.client_count;
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_w.valid;
      end
   end

   assign tok_out = tok_ff;

endmodule
